// ----- rtl/i2cms_pkg.sv -----
// Shared types and constants for the I2C master transaction sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

   // Command codes on the request channel
   localparam logic [2:0] CMD_LOAD  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_EVENT = 3'd2;
   localparam logic [2:0] CMD_TICK  = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // Bus interface status codes (after masking)
   localparam logic [7:0] STATUS_MASK     = 8'hF8;
   localparam logic [7:0] STS_BUS_ERROR   = 8'h00;
   localparam logic [7:0] STS_START       = 8'h08;
   localparam logic [7:0] STS_RESTART     = 8'h10;
   localparam logic [7:0] STS_ADDR_W_ACK  = 8'h18;
   localparam logic [7:0] STS_ADDR_W_NACK = 8'h20;
   localparam logic [7:0] STS_DATA_W_ACK  = 8'h28;
   localparam logic [7:0] STS_DATA_W_NACK = 8'h30;
   localparam logic [7:0] STS_ARB_LOST    = 8'h38;
   localparam logic [7:0] STS_ADDR_R_ACK  = 8'h40;
   localparam logic [7:0] STS_ADDR_R_NACK = 8'h48;
   localparam logic [7:0] STS_DATA_R_ACK  = 8'h50;
   localparam logic [7:0] STS_DATA_R_NACK = 8'h58;
   localparam logic [7:0] STS_NO_INFO     = 8'hF8;

   // Read/write bit of the address byte
   localparam logic [7:0] ADDR_READ_BIT = 8'h01;

   // Outcome codes
   localparam logic [2:0] OUT_NONE    = 3'd0;
   localparam logic [2:0] OUT_SUCCESS = 3'd1;
   localparam logic [2:0] OUT_FAIL    = 3'd2;
   localparam logic [2:0] OUT_TIMEOUT = 3'd3;
   localparam logic [2:0] OUT_REJECT  = 3'd4;

   // Acknowledge mode codes
   localparam logic [1:0] ACK_KEEP = 2'd0;
   localparam logic [1:0] ACK_ACK  = 2'd1;
   localparam logic [1:0] ACK_NACK = 2'd2;

   // Counter saturation value
   localparam logic [5:0] COUNT_MAX = 6'd63;

   // Timeout register reset value
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   // Queue depths and the response queue level width
   localparam int MID_DEPTH  = 2;
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_LVL_W  = $clog2(OUT_DEPTH + 1);

   // Request transaction
   typedef struct packed {
      logic [2:0] cmd;
      logic [4:0] buf_index;
      logic [7:0] load_byte;
      logic [7:0] slave_address;
      logic [5:0] write_length;
      logic [5:0] read_length;
      logic [7:0] status_code;
      logic [7:0] rx_byte;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       start_set;
      logic       start_clear;
      logic       stop_set;
      logic [1:0] ack_mode;
      logic       disable_interface;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       bus_busy;
      logic [2:0] outcome;
      logic [7:0] last_status;
   } rsp_type;

   // Classified operation
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_EVENT,
      OP_TICK,
      OP_READ
   } op_type;

   // Classified command handed from front to back
   typedef struct packed {
      op_type     op;
      logic       idx_ok;
      logic [4:0] idx;
      logic [7:0] load_byte;
      logic [7:0] address;
      logic [5:0] write_len;
      logic [5:0] read_len;
      logic [7:0] status;
      logic [7:0] rx_byte;
   } cmd_type;

endpackage

// ----- rtl/i2cms_fifo.sv -----
// Small register-based FIFO used for the command and response queues.
`timescale 1ns / 1ps

module i2cms_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               push_data,
   input  logic                           pop,
   output logic [WIDTH-1:0]               pop_data,
   output logic                           full,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     level
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    level_ff, level_in;
   logic             do_push, do_pop;

   assign full     = (level_ff == LW'(DEPTH));
   assign empty    = (level_ff == '0);
   assign level    = level_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      level_in = level_ff + LW'(do_push) - LW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/i2cms_front.sv -----
// Front end: decodes and classifies request transactions for the back end.
`timescale 1ns / 1ps

module i2cms_front #(
   parameter int BUF_DEPTH = 32
) (
   input  i2cms_pkg::req_type req,
   output i2cms_pkg::cmd_type cmd
);

   logic [5:0] wl, rl;
   logic [7:0] addr;

   // Clamp lengths to the buffer depth
   always_comb begin
      wl = ({3'b0, req.write_length} > 9'(BUF_DEPTH)) ? 6'(BUF_DEPTH) : req.write_length;
      rl = ({3'b0, req.read_length} > 9'(BUF_DEPTH)) ? 6'(BUF_DEPTH) : req.read_length;
      // read-only transaction starts with the read bit set
      if (wl == 6'd0 && rl != 6'd0) begin
         addr = req.slave_address | i2cms_pkg::ADDR_READ_BIT;
      end else begin
         addr = req.slave_address & ~i2cms_pkg::ADDR_READ_BIT;
      end
   end

   // Command decode
   always_comb begin
      cmd.idx       = req.buf_index;
      cmd.idx_ok    = ({4'b0, req.buf_index} < 9'(BUF_DEPTH));
      cmd.load_byte = req.load_byte;
      cmd.address   = addr;
      cmd.write_len = wl;
      cmd.read_len  = rl;
      cmd.status    = req.status_code & i2cms_pkg::STATUS_MASK;
      cmd.rx_byte   = req.rx_byte;
      unique case (req.cmd)
         i2cms_pkg::CMD_LOAD:  cmd.op = i2cms_pkg::OP_LOAD;
         i2cms_pkg::CMD_START: cmd.op = i2cms_pkg::OP_START;
         i2cms_pkg::CMD_EVENT: cmd.op = i2cms_pkg::OP_EVENT;
         i2cms_pkg::CMD_TICK:  cmd.op = i2cms_pkg::OP_TICK;
         i2cms_pkg::CMD_READ:  cmd.op = i2cms_pkg::OP_READ;
         default:              cmd.op = i2cms_pkg::OP_NONE;
      endcase
   end

endmodule

// ----- rtl/i2cms_back.sv -----
// Back end: transaction state, data buffer and response generation.
`timescale 1ns / 1ps

module i2cms_back #(
   parameter int BUF_DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [15:0]                        timeout_ticks,
   input  logic                               cmd_valid,
   input  i2cms_pkg::cmd_type                 cmd,
   output logic                               cmd_pop,
   input  logic [i2cms_pkg::OUT_LVL_W-1:0]    out_level,
   output logic                               res_valid,
   output i2cms_pkg::rsp_type                 res
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   // Transaction state
   logic [7:0]  address_ff,  address_in;
   logic [5:0]  send_lim_ff, send_lim_in;
   logic [5:0]  recv_lim_ff, recv_lim_in;
   logic [5:0]  count_ff,    count_in;
   logic        busy_ff,     busy_in;
   logic [7:0]  status_ff,   status_in;
   logic [15:0] ticks_ff,    ticks_in;

   // Buffer and its read port
   logic [7:0]  mem_ff [BUF_DEPTH];
   logic [7:0]  rd_ff;
   logic        rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]  wr_data;

   // Response stage
   logic               s2_valid_ff;
   i2cms_pkg::rsp_type s2_res_ff, s2_res_in;
   logic               tx_rd_ff, tx_rd_in;
   logic               rx_rd_ff, rx_rd_in;

   logic        fire;
   logic        count_in_buf;
   logic [8:0]  count_w, idx_w;

   // Issue when the response queue has room for everything in flight
   assign fire    = cmd_valid &&
                    (({1'b0, out_level} + 4'(s2_valid_ff)) < 4'(i2cms_pkg::OUT_DEPTH));
   assign cmd_pop = fire;

   assign count_w      = {3'b0, count_ff};
   assign idx_w        = {4'b0, cmd.idx};
   assign count_in_buf = (count_w < 9'(BUF_DEPTH));

   // Execute one command
   always_comb begin
      address_in  = address_ff;
      send_lim_in = send_lim_ff;
      recv_lim_in = recv_lim_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      status_in   = status_ff;
      ticks_in    = ticks_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = count_w[AW-1:0];
      wr_data     = cmd.rx_byte;
      tx_rd_in    = 1'b0;
      rx_rd_in    = 1'b0;
      s2_res_in   = '0;

      unique case (cmd.op)
         i2cms_pkg::OP_LOAD: begin
            wr_addr = idx_w[AW-1:0];
            wr_data = cmd.load_byte;
            wr_en   = cmd.idx_ok;
         end

         i2cms_pkg::OP_START: begin
            if (busy_ff) begin
               s2_res_in.outcome = i2cms_pkg::OUT_REJECT;
            end else begin
               address_in  = cmd.address;
               send_lim_in = cmd.write_len;
               recv_lim_in = cmd.read_len;
               count_in    = 6'd0;
               busy_in     = 1'b1;
               ticks_in    = timeout_ticks;
               s2_res_in.start_set = 1'b1;
            end
         end

         i2cms_pkg::OP_EVENT: begin
            if (busy_ff) begin
               status_in = cmd.status;
               unique case (cmd.status) inside
                  i2cms_pkg::STS_BUS_ERROR: begin
                     s2_res_in.stop_set = 1'b1;
                     s2_res_in.ack_mode = i2cms_pkg::ACK_ACK;
                     s2_res_in.outcome  = i2cms_pkg::OUT_FAIL;
                     busy_in = 1'b0;
                  end
                  i2cms_pkg::STS_START, i2cms_pkg::STS_RESTART: begin
                     s2_res_in.tx_valid = 1'b1;
                     s2_res_in.tx_byte  = address_ff;
                  end
                  i2cms_pkg::STS_ADDR_W_ACK, i2cms_pkg::STS_DATA_W_ACK: begin
                     if (count_ff < send_lim_ff) begin
                        // next write byte from the buffer
                        s2_res_in.tx_valid    = 1'b1;
                        s2_res_in.start_clear = 1'b1;
                        rd_en    = count_in_buf;
                        rd_addr  = count_w[AW-1:0];
                        tx_rd_in = count_in_buf;
                        count_in = count_ff + 6'd1;
                     end else if (recv_lim_ff == 6'd0) begin
                        s2_res_in.start_clear = 1'b1;
                        s2_res_in.stop_set    = 1'b1;
                        s2_res_in.outcome     = i2cms_pkg::OUT_SUCCESS;
                        busy_in = 1'b0;
                     end else begin
                        // repeated start into the read phase
                        address_in = address_ff | i2cms_pkg::ADDR_READ_BIT;
                        count_in   = 6'd0;
                        s2_res_in.start_set = 1'b1;
                     end
                  end
                  i2cms_pkg::STS_DATA_R_NACK: begin
                     wr_en = count_in_buf;
                     count_in = (count_ff != i2cms_pkg::COUNT_MAX) ? count_ff + 6'd1 : count_ff;
                     s2_res_in.rx_valid    = 1'b1;
                     s2_res_in.rx_data     = cmd.rx_byte;
                     s2_res_in.start_clear = 1'b1;
                     s2_res_in.stop_set    = 1'b1;
                     s2_res_in.outcome     = i2cms_pkg::OUT_SUCCESS;
                     busy_in = 1'b0;
                  end
                  i2cms_pkg::STS_ADDR_W_NACK, i2cms_pkg::STS_DATA_W_NACK,
                  i2cms_pkg::STS_ADDR_R_NACK: begin
                     s2_res_in.start_clear = 1'b1;
                     s2_res_in.stop_set    = 1'b1;
                     s2_res_in.outcome     = i2cms_pkg::OUT_FAIL;
                     busy_in = 1'b0;
                  end
                  i2cms_pkg::STS_ARB_LOST: begin
                     s2_res_in.start_set = 1'b1;
                  end
                  i2cms_pkg::STS_DATA_R_ACK, i2cms_pkg::STS_ADDR_R_ACK: begin
                     if (cmd.status == i2cms_pkg::STS_DATA_R_ACK) begin
                        wr_en = count_in_buf;
                        count_in = (count_ff != i2cms_pkg::COUNT_MAX) ?
                                   count_ff + 6'd1 : count_ff;
                        s2_res_in.rx_valid = 1'b1;
                        s2_res_in.rx_data  = cmd.rx_byte;
                     end
                     // acknowledge unless the next byte is the last
                     s2_res_in.start_clear = 1'b1;
                     s2_res_in.ack_mode =
                        (({1'b0, count_in} + 7'd1) < {1'b0, recv_lim_ff}) ?
                        i2cms_pkg::ACK_ACK : i2cms_pkg::ACK_NACK;
                  end
                  i2cms_pkg::STS_NO_INFO: begin
                  end
                  default: begin
                     s2_res_in.disable_interface = 1'b1;
                     s2_res_in.outcome           = i2cms_pkg::OUT_FAIL;
                     busy_in = 1'b0;
                  end
               endcase
            end
         end

         i2cms_pkg::OP_TICK: begin
            if (busy_ff) begin
               if (ticks_ff == 16'd0) begin
                  s2_res_in.disable_interface = 1'b1;
                  s2_res_in.outcome           = i2cms_pkg::OUT_TIMEOUT;
                  busy_in = 1'b0;
               end else begin
                  ticks_in = ticks_ff - 16'd1;
               end
            end
         end

         i2cms_pkg::OP_READ: begin
            s2_res_in.rx_valid = 1'b1;
            rd_en    = cmd.idx_ok;
            rd_addr  = idx_w[AW-1:0];
            rx_rd_in = cmd.idx_ok;
         end

         default: begin
         end
      endcase

      s2_res_in.bus_busy    = busy_in;
      s2_res_in.last_status = status_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff  <= '0;
         send_lim_ff <= '0;
         recv_lim_ff <= '0;
         count_ff    <= '0;
         busy_ff     <= 1'b0;
         status_ff   <= '0;
         ticks_ff    <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= fire;
         if (fire) begin
            address_ff  <= address_in;
            send_lim_ff <= send_lim_in;
            recv_lim_ff <= recv_lim_in;
            count_ff    <= count_in;
            busy_ff     <= busy_in;
            status_ff   <= status_in;
            ticks_ff    <= ticks_in;
         end
      end
   end

   // Buffer memory and response payload
   always_ff @(posedge clock) begin
      if (fire) begin
         s2_res_ff <= s2_res_in;
         tx_rd_ff  <= tx_rd_in;
         rx_rd_ff  <= rx_rd_in;
         if (wr_en) begin
            mem_ff[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_ff <= mem_ff[rd_addr];
         end
      end
   end

   // Merge buffer read data into the response
   always_comb begin
      res = s2_res_ff;
      if (tx_rd_ff) begin
         res.tx_byte = rd_ff;
      end
      if (rx_rd_ff) begin
         res.rx_data = rd_ff;
      end
   end

   assign res_valid = s2_valid_ff;

endmodule

// ----- rtl/i2c_master_transaction_sequencer_unit.sv -----
// Top level of the I2C master transaction sequencer.
`timescale 1ns / 1ps
//
// Request channel (req_): a queue input. A transaction is taken when req_push
// is high and req_full is low. It carries a load, start, bus status event,
// tick or buffer read command; every transaction yields exactly one response.
// Response channel (rsp_): a queue output. The oldest response is shown while
// rsp_empty is low and is taken when rsp_pop is high.
// CSR port (csr_): APB-style; word 0 holds timeout_ticks (reset 100). Write
// only while no transaction is in flight.
// A request passes through the command queue, the registered response stage
// (which also holds the buffer read data) and the response queue.
// Throughput: one transaction per cycle while the response queue has room;
// the buffer has one read and one write port.
// A stalled receiver fills the four-entry response queue, the back end then
// holds, and the two-entry command queue raises req_full.
// Reset clears the transaction state and both queues and returns timeout_ticks
// to 100; buffer contents are undefined until written.
//
module i2c_master_transaction_sequencer_unit #(
   parameter int BUF_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  i2cms_pkg::req_type req_item,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output i2cms_pkg::rsp_type rsp_item,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int CMD_W = $bits(i2cms_pkg::cmd_type);
   localparam int RSP_W = $bits(i2cms_pkg::rsp_type);

   logic [15:0]                      timeout_ff;
   i2cms_pkg::cmd_type               front_cmd, back_cmd;
   logic [CMD_W-1:0]                 back_cmd_bits;
   logic                             mid_empty, back_pop;
   logic                             res_valid;
   i2cms_pkg::rsp_type               back_res;
   logic [RSP_W-1:0]                 out_bits;
   logic [i2cms_pkg::OUT_LVL_W-1:0]  out_level;
   logic                             csr_write;

   // CSR access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {16'd0, timeout_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= i2cms_pkg::TIMEOUT_RESET;
      end else if (csr_write && !csr_paddr[2]) begin
         timeout_ff <= csr_pwdata[15:0];
      end
   end

   // Front end: classify
   i2cms_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
      .req (req_item),
      .cmd (front_cmd)
   );

   // Command queue between front and back
   i2cms_fifo #(.WIDTH(CMD_W), .DEPTH(i2cms_pkg::MID_DEPTH)) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .pop       (back_pop),
      .pop_data  (back_cmd_bits),
      .full      (req_full),
      .empty     (mid_empty),
      .level     ()
   );

   assign back_cmd = i2cms_pkg::cmd_type'(back_cmd_bits);

   // Back end: execute
   i2cms_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .timeout_ticks (timeout_ff),
      .cmd_valid     (!mid_empty),
      .cmd           (back_cmd),
      .cmd_pop       (back_pop),
      .out_level     (out_level),
      .res_valid     (res_valid),
      .res           (back_res)
   );

   // Response queue
   i2cms_fifo #(.WIDTH(RSP_W), .DEPTH(i2cms_pkg::OUT_DEPTH)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (back_res),
      .pop       (rsp_pop),
      .pop_data  (out_bits),
      .full      (),
      .empty     (rsp_empty),
      .level     (out_level)
   );

   assign rsp_item = i2cms_pkg::rsp_type'(out_bits);

endmodule

// ----- rtl/i2cms_checker.sv -----
// Port-level checks for the I2C master transaction sequencer.
`timescale 1ns / 1ps

module i2cms_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input i2cms_pkg::rsp_type rsp_item
);

   // Nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A finished transaction never reports busy
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_item.outcome == i2cms_pkg::OUT_SUCCESS ||
                      rsp_item.outcome == i2cms_pkg::OUT_FAIL ||
                      rsp_item.outcome == i2cms_pkg::OUT_TIMEOUT))
      |-> !rsp_item.bus_busy)
      else $error("transaction ended but still busy");

   // A rejected start leaves the running transaction alone
   a_reject: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.outcome == i2cms_pkg::OUT_REJECT)
      |-> rsp_item.bus_busy && !rsp_item.start_set)
      else $error("rejected start disturbed the bus");

   // Transmit and receive never happen in one response
   a_tx_rx: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_item.tx_valid && rsp_item.rx_valid))
      else $error("tx and rx in one response");

   // A waiting response holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("response changed while stalled");

endmodule

bind i2c_master_transaction_sequencer_unit i2cms_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_item  (rsp_item)
);

// ----- tb/tb_i2c_master_transaction_sequencer_unit.sv -----
// Testbench for the I2C master transaction sequencer: directed and random bus transactions.
`timescale 1ns / 1ps

module tb_i2c_master_transaction_sequencer_unit;
   import i2cms_pkg::*;

   localparam int BUF_DEPTH = 32;
   localparam logic [2:0] TIMEOUT_ADDR = 3'd0;
   localparam logic [7:0] STS_UNDEFINED = 8'h60;
   localparam int DRAIN_CYCLES = 6;
   localparam int IDLE_LIMIT = 1000;

   // Clock, reset and block ports
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_item = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_item;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Shadow copy of the sequencer state
   logic [7:0] shadow_buf [BUF_DEPTH];
   logic [7:0] shadow_addr = '0;
   logic [5:0] shadow_wr_len = '0;
   logic [5:0] shadow_rd_len = '0;
   logic [5:0] shadow_count = '0;
   logic shadow_busy = 1'b0;
   logic [7:0] shadow_status = '0;
   logic [15:0] shadow_ticks = '0;
   logic [15:0] shadow_timeout = TIMEOUT_RESET;

   // Scoreboard and run control
   rsp_type expected_rsp_q [$];
   rsp_type want_rsp;
   int mismatch_count = 0;
   int effective_items = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   int gap_odds = 0;
   int stall_odds = 0;

   i2c_master_transaction_sequencer_unit #(
      .BUF_DEPTH(BUF_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_item(req_item),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // Lengths above the buffer depth saturate on start
   function automatic logic [5:0] clamp_length(logic [5:0] v);
      return (v > BUF_DEPTH) ? 6'(BUF_DEPTH) : v;
   endfunction

   // Next response of the sequencer; updates the shadow state
   function automatic rsp_type sequencer_next_response(req_type r);
      rsp_type o;
      logic [7:0] code;
      logic [5:0] wl;
      logic [5:0] rl;
      o = '0;
      code = r.status_code & STATUS_MASK;
      case (r.cmd)
         CMD_LOAD: begin
            shadow_buf[r.buf_index] = r.load_byte;
         end
         CMD_START: begin
            if (shadow_busy) begin
               o.outcome = OUT_REJECT;
            end else begin
               wl = clamp_length(r.write_length);
               rl = clamp_length(r.read_length);
               // read-only transfers carry the read bit from the start
               if (wl == 0 && rl != 0) shadow_addr = r.slave_address | ADDR_READ_BIT;
               else shadow_addr = r.slave_address & ~ADDR_READ_BIT;
               shadow_wr_len = wl;
               shadow_rd_len = rl;
               shadow_count = '0;
               shadow_busy = 1'b1;
               shadow_ticks = shadow_timeout;
               o.start_set = 1'b1;
            end
         end
         CMD_EVENT: begin
            if (shadow_busy) begin
               shadow_status = code;
               case (code)
                  STS_BUS_ERROR: begin
                     o.stop_set = 1'b1;
                     o.ack_mode = ACK_ACK;
                     shadow_busy = 1'b0;
                     o.outcome = OUT_FAIL;
                  end
                  STS_START, STS_RESTART: begin
                     o.tx_valid = 1'b1;
                     o.tx_byte = shadow_addr;
                  end
                  STS_ADDR_W_ACK, STS_DATA_W_ACK: begin
                     if (shadow_count < shadow_wr_len) begin
                        o.tx_valid = 1'b1;
                        o.tx_byte = shadow_buf[shadow_count[4:0]];
                        shadow_count++;
                        o.start_clear = 1'b1;
                     end else if (shadow_rd_len == 0) begin
                        o.start_clear = 1'b1;
                        o.stop_set = 1'b1;
                        shadow_busy = 1'b0;
                        o.outcome = OUT_SUCCESS;
                     end else begin
                        // repeated start into the read phase
                        shadow_addr |= ADDR_READ_BIT;
                        shadow_count = '0;
                        o.start_set = 1'b1;
                     end
                  end
                  STS_ADDR_R_ACK, STS_DATA_R_ACK, STS_DATA_R_NACK: begin
                     if (code != STS_ADDR_R_ACK) begin
                        if (shadow_count < BUF_DEPTH) shadow_buf[shadow_count[4:0]] = r.rx_byte;
                        if (shadow_count < COUNT_MAX) shadow_count++;
                        o.rx_valid = 1'b1;
                        o.rx_data = r.rx_byte;
                     end
                     o.start_clear = 1'b1;
                     if (code == STS_DATA_R_NACK) begin
                        o.stop_set = 1'b1;
                        shadow_busy = 1'b0;
                        o.outcome = OUT_SUCCESS;
                     end else begin
                        o.ack_mode = (int'(shadow_count) + 1 < int'(shadow_rd_len)) ?
                                     ACK_ACK : ACK_NACK;
                     end
                  end
                  STS_ADDR_W_NACK, STS_DATA_W_NACK, STS_ADDR_R_NACK: begin
                     o.start_clear = 1'b1;
                     o.stop_set = 1'b1;
                     shadow_busy = 1'b0;
                     o.outcome = OUT_FAIL;
                  end
                  STS_ARB_LOST: begin
                     o.start_set = 1'b1;
                  end
                  STS_NO_INFO: begin
                  end
                  default: begin
                     o.disable_interface = 1'b1;
                     shadow_busy = 1'b0;
                     o.outcome = OUT_FAIL;
                  end
               endcase
            end
         end
         CMD_TICK: begin
            if (shadow_busy) begin
               if (shadow_ticks == 0) begin
                  o.disable_interface = 1'b1;
                  shadow_busy = 1'b0;
                  o.outcome = OUT_TIMEOUT;
               end else begin
                  shadow_ticks--;
               end
            end
         end
         CMD_READ: begin
            o.rx_valid = 1'b1;
            o.rx_data = shadow_buf[r.buf_index];
         end
         default: begin
         end
      endcase
      o.bus_busy = shadow_busy;
      o.last_status = shadow_status;
      return o;
   endfunction

   // Request with every field random except the command
   function automatic req_type random_request(logic [2:0] cmd);
      req_type r;
      logic [31:0] w0;
      logic [31:0] w1;
      w0 = $urandom;
      w1 = $urandom;
      r.cmd = cmd;
      r.buf_index = w0[4:0];
      r.load_byte = w0[12:5];
      r.slave_address = w0[20:13];
      r.write_length = w0[26:21];
      r.read_length = {w0[31:27], w1[0]};
      r.status_code = w1[8:1];
      r.rx_byte = w1[16:9];
      return r;
   endfunction

   // Mostly short transfers, now and then long or saturating
   function automatic logic [5:0] pick_length();
      case ($urandom_range(0, 15))
         0: return 6'($urandom_range(33, 63));
         1: return 6'($urandom_range(5, 32));
         default: return 6'($urandom_range(0, 4));
      endcase
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Drive one request transaction and record its expected response
   task automatic send_request(req_type item);
      if ($urandom_range(1, 100) <= gap_odds) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (!(item.cmd > CMD_READ ||
            (!shadow_busy && (item.cmd == CMD_EVENT || item.cmd == CMD_TICK))))
         effective_items++;
      expected_rsp_q.push_back(sequencer_next_response(item));
   endtask

   task automatic send_simple(logic [2:0] cmd);
      send_request(random_request(cmd));
   endtask

   task automatic send_event(logic [7:0] code);
      req_type r;
      r = random_request(CMD_EVENT);
      r.status_code = {code[7:3], r.status_code[2:0]};
      send_request(r);
   endtask

   task automatic send_start(logic [7:0] addr, logic [5:0] wl, logic [5:0] rl);
      req_type r;
      r = random_request(CMD_START);
      r.slave_address = addr;
      r.write_length = wl;
      r.read_length = rl;
      send_request(r);
   endtask

   task automatic send_buffer_op(logic [2:0] cmd, logic [4:0] idx, logic [7:0] value);
      req_type r;
      r = random_request(cmd);
      r.buf_index = idx;
      r.load_byte = value;
      send_request(r);
   endtask

   // Stray commands mixed into the traffic
   task automatic send_noise();
      case ($urandom_range(0, 7))
         0, 1: send_simple(CMD_TICK);
         2: send_simple(CMD_LOAD);
         3: send_simple(CMD_READ);
         4: send_simple(CMD_EVENT);
         5: send_simple(3'(CMD_READ + $urandom_range(1, 3)));
         6: send_simple(CMD_START);
         default: begin
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 110)) send_simple(CMD_TICK);
            else
               send_simple(CMD_TICK);
         end
      endcase
   endtask

   // Hold the sender until every expected response has come back
   task automatic settle_idle();
      req_push <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_timeout_reg(logic [15:0] want);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= TIMEOUT_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[15:0] != want) begin
         $display("%0t ns: timeout_ticks readback mismatch, expected 0x%0h actual 0x%0h",
                  $time, want, csr_prdata[15:0]);
         mismatch_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_timeout_reg(logic [15:0] value);
      settle_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TIMEOUT_ADDR;
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      shadow_timeout = value;
      @(posedge clock);
      check_timeout_reg(value);
   endtask

   // Reset value of the register, then fill the whole buffer and read back its first, last and one random entry
   task automatic test_buffer_load_and_readback();
      check_timeout_reg(TIMEOUT_RESET);
      for (int i = 0; i < BUF_DEPTH; i++) begin
         if (i == 0) send_buffer_op(CMD_LOAD, 5'(i), 8'h00);
         else if (i == BUF_DEPTH - 1) send_buffer_op(CMD_LOAD, 5'(i), 8'hFF);
         else send_buffer_op(CMD_LOAD, 5'(i), 8'($urandom));
      end
      send_buffer_op(CMD_READ, 5'd0, 8'h00);
      send_buffer_op(CMD_READ, 5'(BUF_DEPTH - 1), 8'h00);
      send_simple(CMD_READ);
   endtask

   // Two bytes out, repeated start, two bytes in
   task automatic test_write_then_read();
      send_start(8'hA5, 6'd2, 6'd2);
      send_event(STS_START);
      send_event(STS_ADDR_W_ACK);
      send_event(STS_DATA_W_ACK);
      send_event(STS_DATA_W_ACK);
      send_event(STS_RESTART);
      send_event(STS_ADDR_R_ACK);
      send_event(STS_DATA_R_ACK);
      send_event(STS_DATA_R_NACK);
      // events and ticks with nothing in progress
      send_event(STS_START);
      send_simple(CMD_TICK);
   endtask

   // Busy rejection, saturation, zero lengths and every error status
   task automatic test_rejects_and_errors();
      send_start(8'h00, 6'd1, 6'd0);
      send_start(8'h3C, 6'd0, 6'd1);
      send_event(STS_BUS_ERROR);
      send_start(8'hFF, 6'd63, 6'd63);
      send_event(STS_START);
      send_event(STS_ARB_LOST);
      send_event(STS_START);
      send_event(STS_ADDR_W_ACK);
      send_event(STS_NO_INFO);
      send_event(STS_ADDR_W_NACK);
      send_start(8'h55, 6'd0, 6'd0);
      send_event(STS_START);
      send_event(STS_ADDR_W_ACK);
      send_start(8'h42, 6'd0, 6'd1);
      send_event(STS_START);
      send_event(STS_ADDR_R_NACK);
      send_start(8'h24, 6'd1, 6'd0);
      send_event(STS_START);
      send_event(STS_ADDR_W_ACK);
      send_event(STS_DATA_W_NACK);
      send_start(8'h81, 6'd0, 6'd1);
      send_event(STS_START);
      send_event(STS_ADDR_R_ACK);
      send_event(STS_DATA_R_NACK);
      send_start(8'h18, 6'd1, 6'd1);
      send_event(STS_UNDEFINED);
      for (int c = 1; c <= 3; c++) send_simple(3'(CMD_READ + c));
   endtask

   // Abort on the first tick at zero, on the third tick at two
   task automatic test_timeout_abort();
      write_timeout_reg(16'd0);
      send_start(8'h10, 6'd1, 6'd1);
      send_simple(CMD_TICK);
      write_timeout_reg(16'd2);
      send_start(8'h10, 6'd1, 6'd1);
      repeat (3) send_simple(CMD_TICK);
      send_simple(CMD_TICK);
   endtask

   // Well-formed transfers with random content, noise and broken sequences
   task automatic test_random_transactions(int target);
      logic [7:0] codes [$];
      logic [5:0] wl;
      logic [5:0] rl;
      logic [5:0] cwl;
      logic [5:0] crl;
      int goal;
      int pick;
      goal = effective_items + target;
      while (effective_items < goal) begin
         if ($urandom_range(1, 100) <= 10) begin
            send_noise();
         end else begin
            wl = pick_length();
            rl = pick_length();
            cwl = clamp_length(wl);
            crl = clamp_length(rl);
            codes.delete();
            codes.push_back(STS_START);
            if (cwl == 0 && crl != 0) begin
               codes.push_back(STS_ADDR_R_ACK);
               repeat (int'(crl) - 1) codes.push_back(STS_DATA_R_ACK);
               codes.push_back(STS_DATA_R_NACK);
            end else begin
               codes.push_back(STS_ADDR_W_ACK);
               repeat (int'(cwl)) codes.push_back(STS_DATA_W_ACK);
               if (crl != 0) begin
                  codes.push_back(STS_RESTART);
                  codes.push_back(STS_ADDR_R_ACK);
                  repeat (int'(crl) - 1) codes.push_back(STS_DATA_R_ACK);
                  codes.push_back(STS_DATA_R_NACK);
               end
            end
            send_start(8'($urandom), wl, rl);
            foreach (codes[k]) begin
               pick = $urandom_range(1, 100);
               if (pick <= 12) send_noise();
               if (pick == 13 || pick == 14) begin
                  // break the transfer with an error status
                  case ($urandom_range(0, 5))
                     0: send_event(STS_BUS_ERROR);
                     1: send_event(STS_ADDR_W_NACK);
                     2: send_event(STS_DATA_W_NACK);
                     3: send_event(STS_ADDR_R_NACK);
                     4: send_event(STS_UNDEFINED);
                     default: send_event(8'($urandom));
                  endcase
                  break;
               end
               if (pick == 15 || pick == 16) begin
                  // lost arbitration, then the start goes out again
                  send_event(STS_ARB_LOST);
                  send_event(STS_START);
               end
               if (pick == 17) break;
               send_event(codes[k]);
            end
         end
      end
   endtask

   // Receiver: stall bursts, and the check of each response transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t ns: unexpected response, expected none actual 0x%h",
                        $time, rsp_item);
               mismatch_count++;
            end else begin
               want_rsp = expected_rsp_q.pop_front();
               check_field("tx_valid", want_rsp.tx_valid, rsp_item.tx_valid);
               check_field("tx_byte", want_rsp.tx_byte, rsp_item.tx_byte);
               check_field("start_set", want_rsp.start_set, rsp_item.start_set);
               check_field("start_clear", want_rsp.start_clear, rsp_item.start_clear);
               check_field("stop_set", want_rsp.stop_set, rsp_item.stop_set);
               check_field("ack_mode", want_rsp.ack_mode, rsp_item.ack_mode);
               check_field("disable_interface", want_rsp.disable_interface,
                           rsp_item.disable_interface);
               check_field("rx_valid", want_rsp.rx_valid, rsp_item.rx_valid);
               check_field("rx_data", want_rsp.rx_data, rsp_item.rx_data);
               check_field("bus_busy", want_rsp.bus_busy, rsp_item.bus_busy);
               check_field("outcome", want_rsp.outcome, rsp_item.outcome);
               check_field("last_status", want_rsp.last_status, rsp_item.last_status);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if ($urandom_range(1, 100) <= stall_odds) begin
            stall_left = $urandom_range(0, 14);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Cycles in which no transaction moves on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : main_sequence
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      gap_odds = 20;
      stall_odds = 10;
      test_buffer_load_and_readback();
      test_write_then_read();
      test_rejects_and_errors();
      test_timeout_abort();
      write_timeout_reg(TIMEOUT_RESET);
      test_random_transactions(350);
      write_timeout_reg(16'd1);
      test_random_transactions(300);
      // full-rate sender against a slow receiver
      gap_odds = 0;
      stall_odds = 40;
      write_timeout_reg(16'hFFFF);
      test_random_transactions(350);
      gap_odds = 30;
      stall_odds = 5;
      write_timeout_reg(16'd0);
      test_random_transactions(200);
      gap_odds = 20;
      stall_odds = 10;
      write_timeout_reg(16'($urandom_range(2, 400)));
      test_random_transactions(300);
      // closing stretch without idling
      write_timeout_reg(TIMEOUT_RESET);
      gap_odds = 0;
      stall_odds = 0;
      test_random_transactions(350);
      settle_idle();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
